// File: hw/rtl/mbp_pkg.sv
package mbp_pkg;

    localparam int MAX_BOUNDARY_DEF = 32;
    localparam int LEN_W            = 6;
    localparam int POS_W            = 5;
    localparam int BYTE_W           = 8;

    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_HYPHEN = 8'h2d;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // result kinds
    typedef enum logic [3:0] {
        K_FIELD = 4'd0,
        K_VALUE = 4'd1,
        K_DATA  = 4'd2,
        K_BEGIN = 4'd3,
        K_HDONE = 4'd4,
        K_PEND  = 4'd5,
        K_BEND  = 4'd6,
        K_ERR   = 4'd7,
        K_FDONE = 4'd8,
        K_VDONE = 4'd9
    } t_kind;

    // input commands
    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_PARSE = 1'b1
    } t_cmd;

    // parser states
    typedef enum logic [3:0] {
        PS_BOUNDARY     = 4'd0,
        PS_FIELD_START  = 4'd1,
        PS_FIELD        = 4'd2,
        PS_HDRS_ALMOST  = 4'd3,
        PS_VALUE_START  = 4'd4,
        PS_VALUE        = 4'd5,
        PS_VALUE_ALMOST = 4'd6,
        PS_DATA_START   = 4'd7,
        PS_DATA         = 4'd8,
        PS_ALMOST_BND   = 4'd9,
        PS_DATA_BND     = 4'd10,
        PS_ALMOST_END   = 4'd11,
        PS_DATA_END     = 4'd12,
        PS_FINAL_HYPHEN = 4'd13,
        PS_END          = 4'd14,
        PS_ERROR        = 4'd15
    } t_pstate;

    // output sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_EV0  = 3'd1,
        PH_CR   = 3'd2,
        PH_LF   = 3'd3,
        PH_TAB  = 3'd4,
        PH_TAIL = 3'd5
    } t_phase;

    // beats owed for one body byte: an event, a release of held bytes, a data byte
    typedef struct packed {
        logic              ev0_en;
        t_kind             ev0_kind;
        logic [BYTE_W-1:0] ev0_byte;
        logic              rel_en;
        logic              tail_en;
        logic [BYTE_W-1:0] data;
    } t_job;

endpackage

// File: hw/rtl/multipart_body_parser_core.sv
// channel   | dir | tdata                                   | tuser       | tlast
// ----------+-----+-----------------------------------------+-------------+------------
// s_axis    | in  | [4:0] boundary_pos, [12:5] byte_value   | [0] cmd     | -
// m_axis    | out | [7:0] out_byte                          | [3:0] kind  | last
// cfg       | in  | wr_data [5:0] boundary_length           | -           | -
//
// input: a beat that causes at most one result is taken while the sequencer stays idle;
//   otherwise s_axis_tready stays low until its last result beat is registered (a failed
//   boundary match gives cr, lf, the k held bytes and, unless the byte is a cr, the byte itself)
// the boundary table has a registered read; the entry at the next match count (or, during
//   a release, the next held index) is prefetched so a compare never waits
// reset clears parser and sequencer state and sets the boundary length to one; table entries are undefined until loaded
// a stalled m_axis holds the output register and drops s_axis_tready
module multipart_body_parser_core #(
    parameter int MAX_BOUNDARY = mbp_pkg::MAX_BOUNDARY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_wr_en,
    input  logic [mbp_pkg::LEN_W-1:0] i_cfg_wr_data,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [4:0] boundary_pos, [12:5] byte_value
    input  logic        i_s_axis_tuser,   // [0] cmd
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] out_byte
    output logic [3:0]  o_m_axis_tuser,   // [3:0] kind
    output logic        o_m_axis_tlast    // last
);
    import mbp_pkg::*;

    localparam int AW = (MAX_BOUNDARY > 1) ? $clog2(MAX_BOUNDARY) : 1;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_BOUNDARY);

    // input fields
    logic [POS_W-1:0]  in_pos;
    logic [BYTE_W-1:0] c;
    t_cmd              in_cmd;
    logic              in_acc;

    assign in_pos = i_s_axis_tdata[4:0];
    assign c      = i_s_axis_tdata[12:5];
    assign in_cmd = t_cmd'(i_s_axis_tuser);

    // control registers
    logic [LEN_W-1:0] r_blen;
    t_pstate          r_pstate, n_pstate;
    logic [LEN_W-1:0] r_match, n_match;
    t_phase           r_phase, n_phase;
    logic             r_m_valid;

    // payload registers
    t_job             r_job;
    logic [LEN_W-1:0] r_rel_cnt;
    logic [LEN_W-1:0] r_tab_idx, n_tab_idx;
    t_kind            r_m_kind;
    logic [7:0]       r_m_byte;
    logic             r_m_last;

    // effective boundary length, clamped to 1..MAX_BOUNDARY
    logic [LEN_W-1:0] len;
    logic [LEN_W:0]   len_p1;
    always_comb begin
        if (r_blen == '0) begin
            len = LEN_W'(1);
        end else if (r_blen > LEN_MAX) begin
            len = LEN_MAX;
        end else begin
            len = r_blen;
        end
    end
    assign len_p1 = {1'b0, len} + (LEN_W+1)'(1);

    // output slot and input handshake
    logic slot_free;
    assign slot_free       = !r_m_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_phase == PH_IDLE) && slot_free;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    // boundary table
    logic [7:0]    r_tab [MAX_BOUNDARY];
    logic [7:0]    r_tab_q;
    logic          r_fwd;
    logic [7:0]    r_fwd_byte;
    logic          tab_we;
    logic [AW-1:0] tab_wa, tab_ra;
    logic [7:0]    tv;

    assign tab_we = in_acc && (in_cmd == CMD_LOAD) && ({1'b0, in_pos} < LEN_MAX);
    assign tab_wa = AW'(in_pos);
    assign tab_ra = (n_phase == PH_TAB) ? AW'(n_tab_idx) : AW'(n_match);
    assign tv     = r_fwd ? r_fwd_byte : r_tab_q;

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab[tab_wa] <= c;
        end
        r_tab_q    <= r_tab[tab_ra];
        r_fwd      <= tab_we && (tab_wa == tab_ra);
        r_fwd_byte <= c;
    end

    // byte classes
    logic is_letter, parse_acc, bnd_fail, bnd_done;
    always_comb begin
        is_letter = (c | 8'h20) inside {[8'h61:8'h7a]};
    end
    assign parse_acc = in_acc && (in_cmd == CMD_PARSE);
    assign bnd_fail  = (r_match >= len) || (c != tv);
    assign bnd_done  = (r_match + LEN_W'(1)) == len;

    // parser next state
    always_comb begin
        n_pstate = r_pstate;
        n_match  = r_match;
        if (in_acc && in_cmd == CMD_LOAD) begin
            n_pstate = PS_BOUNDARY;
            n_match  = '0;
        end else if (parse_acc) begin
            case (r_pstate)
                PS_BOUNDARY: begin
                    if (r_match == len) begin
                        if (c == CH_CR) n_match = r_match + LEN_W'(1);
                        else            n_pstate = PS_ERROR;
                    end else if ({1'b0, r_match} == len_p1) begin
                        if (c == CH_LF) begin
                            n_match  = '0;
                            n_pstate = PS_FIELD_START;
                        end else begin
                            n_pstate = PS_ERROR;
                        end
                    end else if (({1'b0, r_match} > len_p1) || (c != tv)) begin
                        n_pstate = PS_ERROR;
                    end else begin
                        n_match = r_match + LEN_W'(1);
                    end
                end
                PS_FIELD_START, PS_FIELD: begin
                    if (c == CH_CR)                        n_pstate = PS_HDRS_ALMOST;
                    else if (c == CH_COLON)                n_pstate = PS_VALUE_START;
                    else if (c == CH_HYPHEN || is_letter)  n_pstate = PS_FIELD;
                    else                                   n_pstate = PS_ERROR;
                end
                PS_HDRS_ALMOST: begin
                    n_pstate = (c == CH_LF) ? PS_DATA_START : PS_ERROR;
                end
                PS_VALUE_START: begin
                    if (c != CH_SPACE) begin
                        n_pstate = (c == CH_CR) ? PS_VALUE_ALMOST : PS_VALUE;
                    end
                end
                PS_VALUE: begin
                    n_pstate = (c == CH_CR) ? PS_VALUE_ALMOST : PS_VALUE;
                end
                PS_VALUE_ALMOST: begin
                    n_pstate = (c == CH_LF) ? PS_FIELD_START : PS_ERROR;
                end
                PS_DATA_START, PS_DATA: begin
                    n_pstate = (c == CH_CR) ? PS_ALMOST_BND : PS_DATA;
                end
                PS_ALMOST_BND: begin
                    if (c == CH_LF) begin
                        n_pstate = PS_DATA_BND;
                        n_match  = '0;
                    end else begin
                        n_pstate = (c == CH_CR) ? PS_ALMOST_BND : PS_DATA;
                    end
                end
                PS_DATA_BND: begin
                    if (bnd_fail) begin
                        n_match  = '0;
                        n_pstate = (c == CH_CR) ? PS_ALMOST_BND : PS_DATA;
                    end else begin
                        n_match = r_match + LEN_W'(1);
                        if (bnd_done) n_pstate = PS_ALMOST_END;
                    end
                end
                PS_ALMOST_END: begin
                    if (c == CH_HYPHEN)  n_pstate = PS_FINAL_HYPHEN;
                    else if (c == CH_CR) n_pstate = PS_DATA_END;
                    else                 n_pstate = PS_ERROR;
                end
                PS_FINAL_HYPHEN: begin
                    n_pstate = (c == CH_HYPHEN) ? PS_END : PS_ERROR;
                end
                PS_DATA_END: begin
                    n_pstate = (c == CH_LF) ? PS_FIELD_START : PS_ERROR;
                end
                default: begin
                    n_pstate = r_pstate;
                end
            endcase
        end
    end

    // beats owed for the byte being accepted
    t_job             new_job;
    logic [LEN_W-1:0] new_rel_cnt;

    assign new_rel_cnt = (r_match < len) ? r_match : len;

    always_comb begin
        new_job      = '0;
        new_job.data = c;
        if (parse_acc) begin
            case (r_pstate)
                PS_BOUNDARY: begin
                    if (r_match == len) begin
                        if (c != CH_CR) begin
                            new_job.ev0_en   = 1'b1;
                            new_job.ev0_kind = K_ERR;
                        end
                    end else if ({1'b0, r_match} == len_p1) begin
                        new_job.ev0_en   = 1'b1;
                        new_job.ev0_kind = (c == CH_LF) ? K_BEGIN : K_ERR;
                    end else if (({1'b0, r_match} > len_p1) || (c != tv)) begin
                        new_job.ev0_en   = 1'b1;
                        new_job.ev0_kind = K_ERR;
                    end
                end
                PS_FIELD_START, PS_FIELD: begin
                    if (c == CH_COLON) begin
                        new_job.ev0_en   = 1'b1;
                        new_job.ev0_kind = K_FDONE;
                    end else if (c == CH_HYPHEN || is_letter) begin
                        new_job.ev0_en   = 1'b1;
                        new_job.ev0_kind = K_FIELD;
                        new_job.ev0_byte = c;
                    end else if (c != CH_CR) begin
                        new_job.ev0_en   = 1'b1;
                        new_job.ev0_kind = K_ERR;
                    end
                end
                PS_HDRS_ALMOST, PS_VALUE_ALMOST, PS_DATA_END: begin
                    new_job.ev0_en   = 1'b1;
                    new_job.ev0_kind = K_ERR;
                    if (c == CH_LF) begin
                        new_job.ev0_en   = (r_pstate == PS_DATA_END);
                        new_job.ev0_kind = K_BEGIN;
                    end
                end
                PS_VALUE_START, PS_VALUE: begin
                    if (r_pstate == PS_VALUE || c != CH_SPACE) begin
                        new_job.ev0_en = 1'b1;
                        if (c == CH_CR) begin
                            new_job.ev0_kind = K_VDONE;
                        end else begin
                            new_job.ev0_kind = K_VALUE;
                            new_job.ev0_byte = c;
                        end
                    end
                end
                PS_DATA_START: begin
                    new_job.ev0_en   = 1'b1;
                    new_job.ev0_kind = K_HDONE;
                    new_job.tail_en  = (c != CH_CR);
                end
                PS_DATA: begin
                    new_job.tail_en = (c != CH_CR);
                end
                PS_ALMOST_BND: begin
                    if (c != CH_LF) begin
                        new_job.ev0_en   = 1'b1;
                        new_job.ev0_kind = K_DATA;
                        new_job.ev0_byte = CH_CR;
                        new_job.tail_en  = (c != CH_CR);
                    end
                end
                PS_DATA_BND: begin
                    if (bnd_fail) begin
                        new_job.rel_en  = 1'b1;
                        new_job.tail_en = (c != CH_CR);
                    end else if (bnd_done) begin
                        new_job.ev0_en   = 1'b1;
                        new_job.ev0_kind = K_PEND;
                    end
                end
                PS_ALMOST_END: begin
                    if (c != CH_HYPHEN && c != CH_CR) begin
                        new_job.ev0_en   = 1'b1;
                        new_job.ev0_kind = K_ERR;
                    end
                end
                PS_FINAL_HYPHEN: begin
                    new_job.ev0_en   = 1'b1;
                    new_job.ev0_kind = (c == CH_HYPHEN) ? K_BEND : K_ERR;
                end
                default: begin
                    new_job.ev0_en = 1'b0;
                end
            endcase
        end
    end

    // sequencer: while idle the first beat leaves in the accept cycle
    t_job             cur_job;
    logic [LEN_W-1:0] cur_cnt, cur_idx;
    t_phase           cur_ph, nxt_ph, after_rel;
    logic             emit, beat_last;

    assign cur_job = (r_phase == PH_IDLE) ? new_job : r_job;
    assign cur_cnt = (r_phase == PH_IDLE) ? new_rel_cnt : r_rel_cnt;
    assign cur_idx = (r_phase == PH_IDLE) ? '0 : r_tab_idx;

    always_comb begin
        if (r_phase != PH_IDLE)   cur_ph = r_phase;
        else if (new_job.ev0_en)  cur_ph = PH_EV0;
        else if (new_job.rel_en)  cur_ph = PH_CR;
        else if (new_job.tail_en) cur_ph = PH_TAIL;
        else                      cur_ph = PH_IDLE;
    end

    assign emit      = (cur_ph != PH_IDLE) && slot_free;
    assign after_rel = cur_job.tail_en ? PH_TAIL : PH_IDLE;

    // sequencer next state
    always_comb begin
        case (cur_ph)
            PH_EV0:  nxt_ph = cur_job.rel_en ? PH_CR : after_rel;
            PH_CR:   nxt_ph = PH_LF;
            PH_LF:   nxt_ph = (cur_cnt != '0) ? PH_TAB : after_rel;
            PH_TAB: begin
                nxt_ph = ((cur_idx + LEN_W'(1)) < cur_cnt) ? PH_TAB : after_rel;
            end
            PH_TAIL: nxt_ph = PH_IDLE;
            default: nxt_ph = PH_IDLE;
        endcase
        n_phase   = emit ? nxt_ph : r_phase;
        n_tab_idx = r_tab_idx;
        if (emit) begin
            n_tab_idx = (cur_ph == PH_TAB) ? (cur_idx + LEN_W'(1)) : '0;
        end
    end

    assign beat_last = (nxt_ph == PH_IDLE);

    // sequencer outputs: the beat for the current phase
    t_kind      beat_kind;
    logic [7:0] beat_byte;
    always_comb begin
        case (cur_ph)
            PH_EV0: begin
                beat_kind = cur_job.ev0_kind;
                beat_byte = cur_job.ev0_byte;
            end
            PH_CR: begin
                beat_kind = K_DATA;
                beat_byte = CH_CR;
            end
            PH_LF: begin
                beat_kind = K_DATA;
                beat_byte = CH_LF;
            end
            PH_TAB: begin
                beat_kind = K_DATA;
                beat_byte = tv;
            end
            PH_TAIL: begin
                beat_kind = K_DATA;
                beat_byte = cur_job.data;
            end
            default: begin
                beat_kind = K_FIELD;
                beat_byte = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blen    <= LEN_W'(1);
            r_pstate  <= PS_BOUNDARY;
            r_match   <= '0;
            r_phase   <= PH_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_blen <= i_cfg_wr_data;
            end
            r_pstate <= n_pstate;
            r_match  <= n_match;
            r_phase  <= n_phase;
            if (emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_phase == PH_IDLE) begin
            r_job     <= new_job;
            r_rel_cnt <= new_rel_cnt;
        end
        r_tab_idx <= n_tab_idx;
        if (emit) begin
            r_m_kind <= beat_kind;
            r_m_byte <= beat_byte;
            r_m_last <= beat_last;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_byte;
    assign o_m_axis_tuser  = r_m_kind;
    assign o_m_axis_tlast  = r_m_last;

    // an error is sticky until the next boundary load
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pstate == PS_ERROR) && !(in_acc && in_cmd == CMD_LOAD) |=> r_pstate == PS_ERROR)
        else $error("parser left error state without a load");

    // release never reads past the held byte count
    a_tab_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TAB) |-> (r_tab_idx < r_rel_cnt))
        else $error("release index beyond held bytes");

    // the last beat of a byte returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && beat_last |=> r_phase == PH_IDLE)
        else $error("sequencer busy after last beat");

    // after body end, bytes give no result
    a_end_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        parse_acc && (r_pstate == PS_END) |-> !emit)
        else $error("result after body end");

endmodule

// File: verif/testbench.sv
module testbench;
    import mbp_pkg::*;

    localparam int TBL_DEPTH     = MAX_BOUNDARY_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 48;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_BYTES   = 30;

    // one beat offered on the input stream
    typedef struct packed {
        t_cmd              cmd;
        logic [POS_W-1:0]  pos;
        logic [7:0]        val;
    } t_item;

    // one result beat as the parser should emit it
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_beat;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic [LEN_W-1:0]  cfg_wr_data   = '0;
    logic              s_tvalid      = 1'b0;
    logic [15:0]       s_tdata       = '0;
    logic              s_tuser       = 1'b0;
    logic              m_tready      = 1'b0;
    logic              s_tready;
    logic              m_tvalid;
    logic [7:0]        m_tdata;
    logic [3:0]        m_tuser;
    logic              m_tlast;

    // stimulus side
    t_item             tx_items[$];
    bit                offering      = 1'b0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                holdoff_left  = 0;
    logic [7:0]        bnd_mirror [TBL_DEPTH];
    int                bnd_len       = 1;

    // parser model
    logic [7:0]        tbl_model [TBL_DEPTH];
    logic [LEN_W-1:0]  len_reg       = 6'd1;
    t_pstate           pstate        = PS_BOUNDARY;
    logic [5:0]        match_cnt     = '0;
    t_beat             step_beats[$];
    t_beat             owed_results[$];

    // bookkeeping
    int                cycle_cnt     = 0;
    int                mismatches    = 0;
    int                n_body        = 0;
    int                n_loads       = 0;
    int                n_checked     = 0;
    int                n_settings    = 0;
    logic [15:0]       kinds_seen    = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    multipart_body_parser_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),     // [4:0] boundary_pos, [12:5] byte_value
        .i_s_axis_tuser  (s_tuser),     // [0] cmd
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),     // [7:0] out_byte
        .o_m_axis_tuser  (m_tuser),     // [3:0] kind
        .o_m_axis_tlast  (m_tlast)      // last
    );

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------

    // length 0 compares one byte, anything past the table compares the whole table
    function automatic int clamp_len(logic [LEN_W-1:0] v);
        if (v == 0) return 1;
        if (v > TBL_DEPTH) return TBL_DEPTH;
        return int'(v);
    endfunction

    function automatic logic [7:0] tbl_at(int i);
        return (i < TBL_DEPTH) ? tbl_model[i] : 8'h00;
    endfunction

    task automatic push_result(t_kind k, logic [7:0] b);
        step_beats.push_back('{kind: k, data: b, last: 1'b0});
    endtask

    // bad byte: one error beat, then deaf until the next table load
    task automatic fail_parse();
        push_result(K_ERR, 8'h00);
        pstate = PS_ERROR;
    endtask

    // part data byte; also re-examines a byte after a broken boundary match
    task automatic data_in(logic [7:0] c);
        if (c == CH_CR) begin
            pstate = PS_ALMOST_BND;
        end else begin
            push_result(K_DATA, c);
            pstate = PS_DATA;
        end
    endtask

    task automatic value_in(logic [7:0] c);
        if (c == CH_CR) begin
            push_result(K_VDONE, 8'h00);
            pstate = PS_VALUE_ALMOST;
        end else begin
            push_result(K_VALUE, c);
            pstate = PS_VALUE;
        end
    endtask

    task automatic advance_parser(logic [7:0] c);
        int len;
        int i;
        logic [7:0] folded;
        len = clamp_len(len_reg);
        folded = c | 8'h20;
        case (pstate)
            PS_BOUNDARY: begin
                if (match_cnt == len) begin
                    if (c != CH_CR) fail_parse();
                    else match_cnt++;
                end else if (match_cnt == len + 1) begin
                    if (c != CH_LF) begin
                        fail_parse();
                    end else begin
                        match_cnt = '0;
                        push_result(K_BEGIN, 8'h00);
                        pstate = PS_FIELD_START;
                    end
                end else if (match_cnt > len + 1 || c != tbl_at(match_cnt)) begin
                    fail_parse();
                end else begin
                    match_cnt++;
                end
            end
            PS_FIELD_START, PS_FIELD: begin
                pstate = PS_FIELD;
                // a cr inside a name ends the headers, the partial name gets no done beat
                if (c == CH_CR) begin
                    pstate = PS_HDRS_ALMOST;
                end else if (c == CH_COLON) begin
                    push_result(K_FDONE, 8'h00);
                    pstate = PS_VALUE_START;
                end else if (c == CH_HYPHEN || (folded >= 8'h61 && folded <= 8'h7a)) begin
                    push_result(K_FIELD, c);
                end else begin
                    fail_parse();
                end
            end
            PS_HDRS_ALMOST: begin
                if (c != CH_LF) fail_parse();
                else pstate = PS_DATA_START;
            end
            PS_VALUE_START: begin
                if (c != CH_SPACE) value_in(c);
            end
            PS_VALUE:       value_in(c);
            PS_VALUE_ALMOST: begin
                if (c != CH_LF) fail_parse();
                else pstate = PS_FIELD_START;
            end
            PS_DATA_START: begin
                push_result(K_HDONE, 8'h00);
                data_in(c);
            end
            PS_DATA:        data_in(c);
            PS_ALMOST_BND: begin
                if (c == CH_LF) begin
                    pstate = PS_DATA_BND;
                    match_cnt = '0;
                end else begin
                    push_result(K_DATA, CH_CR);
                    data_in(c);
                end
            end
            PS_DATA_BND: begin
                if (match_cnt >= len || c != tbl_at(match_cnt)) begin
                    // not a boundary after all: give back cr lf and the matched prefix
                    push_result(K_DATA, CH_CR);
                    push_result(K_DATA, CH_LF);
                    for (i = 0; i < match_cnt && i < len; i++)
                        push_result(K_DATA, tbl_at(i));
                    match_cnt = '0;
                    data_in(c);
                end else begin
                    match_cnt++;
                    if (match_cnt == len) begin
                        push_result(K_PEND, 8'h00);
                        pstate = PS_ALMOST_END;
                    end
                end
            end
            PS_ALMOST_END: begin
                if (c == CH_HYPHEN) pstate = PS_FINAL_HYPHEN;
                else if (c == CH_CR) pstate = PS_DATA_END;
                else fail_parse();
            end
            PS_FINAL_HYPHEN: begin
                if (c != CH_HYPHEN) begin
                    fail_parse();
                end else begin
                    push_result(K_BEND, 8'h00);
                    pstate = PS_END;
                end
            end
            PS_DATA_END: begin
                if (c != CH_LF) begin
                    fail_parse();
                end else begin
                    push_result(K_BEGIN, 8'h00);
                    pstate = PS_FIELD_START;
                end
            end
            default: ;  // body end and error: byte dropped
        endcase
    endtask

    // works out the beats owed for one accepted input beat
    task automatic predict_item(t_item it);
        step_beats.delete();
        if (it.cmd == CMD_LOAD) begin
            tbl_model[it.pos] = it.val;
            pstate = PS_BOUNDARY;
            match_cnt = '0;
        end else begin
            advance_parser(it.val);
        end
        if (step_beats.size() > 0)
            step_beats[step_beats.size() - 1].last = 1'b1;
        foreach (step_beats[i])
            owed_results.push_back(step_beats[i]);
    endtask

    // ------------------------------------------------------------------
    // monitor and scoreboard: both streams sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_item it;
        t_beat want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still owed",
                     cycle_cnt, owed_results.size());
            $display("*** FAILED ***");
            $finish;
        end else if (i_rst_n) begin
            if (cfg_wr_en)
                len_reg = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                it = tx_items.pop_front();
                offering = 1'b0;
                if (it.cmd == CMD_LOAD) n_loads++;
                else n_body++;
                predict_item(it);
            end
            if (m_tvalid && m_tready) begin
                n_checked++;
                kinds_seen[m_tuser] = 1'b1;
                if (owed_results.size() == 0) begin
                    $error("unexpected result beat: kind %0d byte %02h last %0d",
                           m_tuser, m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    want = owed_results.pop_front();
                    if (want.kind !== m_tuser) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                        mismatches++;
                    end
                    if (want.data !== m_tdata) begin
                        $error("out_byte: expected %02h, got %02h", want.data, m_tdata);
                        mismatches++;
                    end
                    if (want.last !== m_tlast) begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // driver: offers the queue head at the falling edge, holds it until taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : feeder
        if (i_rst_n && !offering) begin
            if (tx_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {3'b000, tx_items[0].val, tx_items[0].pos};
                s_tuser  <= tx_items[0].cmd;
                offering = 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure; a hold-off keeps tready low for a counted stretch
    always @(negedge i_clk) begin : sink_ready
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic push_item(t_cmd c, logic [POS_W-1:0] p, logic [7:0] v);
        tx_items.push_back('{cmd: c, pos: p, val: v});
    endtask

    // body byte with a small chance of being swapped for garbage
    task automatic push_body(logic [7:0] b);
        logic [7:0] v;
        v = b;
        if ($urandom_range(0, 99) == 0)
            v = 8'($urandom_range(0, 255));
        push_item(CMD_PARSE, 5'($urandom_range(0, 31)), v);
    endtask

    function automatic logic [7:0] any_but_cr();
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255)); while (v == CH_CR);
        return v;
    endfunction

    function automatic logic [7:0] name_char();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0) return CH_HYPHEN;
        if (r < 3) return 8'h41 + 8'($urandom_range(0, 25));
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] boundary_char();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 8'($urandom_range(0, 255));
        if (r == 1) return CH_HYPHEN;
        if (r < 5) return 8'h30 + 8'($urandom_range(0, 9));
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    task automatic push_crlf_boundary();
        push_body(CH_CR);
        push_body(CH_LF);
        for (int i = 0; i < bnd_len; i++)
            push_body(bnd_mirror[i]);
    endtask

    // one well-formed body with random content: 1-2 parts, short headers and data
    task automatic gen_body();
        int parts;
        int hdrs;
        int n;
        int k;
        int p;
        p = $urandom_range(0, TBL_DEPTH - 1);
        // reloading an entry with its own byte restarts the parser cleanly
        push_item(CMD_LOAD, 5'(p), bnd_mirror[p]);
        for (int i = 0; i < bnd_len; i++)
            push_body(bnd_mirror[i]);
        push_body(CH_CR);
        push_body(CH_LF);
        parts = $urandom_range(1, 2);
        for (int pt = 0; pt < parts; pt++) begin
            hdrs = $urandom_range(0, 2);
            for (int h = 0; h < hdrs; h++) begin
                n = $urandom_range(1, 3);
                repeat (n) push_body(name_char());
                push_body(CH_COLON);
                n = $urandom_range(0, 2);
                repeat (n) push_body(CH_SPACE);
                n = $urandom_range(0, 3);
                repeat (n) push_body(any_but_cr());
                push_body(CH_CR);
                push_body(CH_LF);
            end
            push_body(CH_CR);
            push_body(CH_LF);
            n = $urandom_range(0, 5);
            for (int d = 0; d < n; d++) begin
                case ($urandom_range(0, 5))
                    0: push_body(CH_CR);
                    1: begin
                        // cr lf and a boundary prefix that is then broken off
                        k = $urandom_range(0, bnd_len - 1);
                        push_body(CH_CR);
                        push_body(CH_LF);
                        for (int i = 0; i < k; i++)
                            push_body(bnd_mirror[i]);
                        push_body(8'($urandom_range(0, 255)));
                    end
                    default: push_body(8'($urandom_range(0, 255)));
                endcase
            end
            push_crlf_boundary();
            if (pt == parts - 1) begin
                push_body(CH_HYPHEN);
                push_body(CH_HYPHEN);
            end else begin
                push_body(CH_CR);
                push_body(CH_LF);
            end
        end
        // trailing bytes after the body end
        n = $urandom_range(0, 2);
        repeat (n) push_body(8'($urandom_range(0, 255)));
    endtask

    // sender stops until every owed beat is out, then lets the block settle
    task automatic wait_drained(int extra);
        while (tx_items.size() != 0 || offering || owed_results.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_len(logic [LEN_W-1:0] v);
        @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
        bnd_len = clamp_len(v);
        n_settings++;
    endtask

    initial begin : stimulus
        int send_pct [4];
        int recv_pct [4];
        logic [LEN_W-1:0] len_plan [NUM_PHASES];
        int start_cnt;
        send_pct = '{0, 67, 0, 23};
        recv_pct = '{0, 0, 67, 23};
        len_plan = '{6'd0, 6'd3, 6'd63, 6'd2, 6'd1, 6'd4};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill the whole table once, so every entry is defined from here on
        for (int p = 0; p < TBL_DEPTH; p++) begin
            bnd_mirror[p] = boundary_char();
            push_item(CMD_LOAD, 5'(p), bnd_mirror[p]);
        end

        // directed part, boundary length still at its reset value of one
        send_pct[0] = 0;
        bnd_mirror[31] = 8'hff;
        bnd_mirror[0]  = 8'h7a;
        push_item(CMD_LOAD, 5'd31, 8'hff);
        push_item(CMD_LOAD, 5'd0, 8'h7a);
        push_item(CMD_PARSE, 5'd31, 8'h7a);      // boundary
        push_item(CMD_PARSE, 5'd0, CH_CR);
        push_item(CMD_PARSE, 5'd0, CH_LF);       // part begin
        push_item(CMD_PARSE, 5'd0, 8'h41);       // header name, letter and hyphen
        push_item(CMD_PARSE, 5'd0, CH_HYPHEN);
        push_item(CMD_PARSE, 5'd0, CH_COLON);    // field done
        push_item(CMD_PARSE, 5'd0, CH_SPACE);    // skipped leading space
        push_item(CMD_PARSE, 5'd0, 8'h76);
        push_item(CMD_PARSE, 5'd0, CH_CR);       // value done
        push_item(CMD_PARSE, 5'd0, CH_LF);
        push_item(CMD_PARSE, 5'd0, 8'h42);       // partial name cut by a blank line
        push_item(CMD_PARSE, 5'd0, CH_CR);
        push_item(CMD_PARSE, 5'd0, CH_LF);
        push_item(CMD_PARSE, 5'd0, 8'hff);       // headers complete plus data
        push_item(CMD_PARSE, 5'd0, CH_CR);
        push_item(CMD_PARSE, 5'd0, 8'h00);       // lone cr released as data
        push_item(CMD_PARSE, 5'd0, CH_CR);
        push_item(CMD_PARSE, 5'd0, CH_LF);
        push_item(CMD_PARSE, 5'd0, 8'h7a);       // part end
        push_item(CMD_PARSE, 5'd0, CH_HYPHEN);
        push_item(CMD_PARSE, 5'd0, CH_HYPHEN);   // body end
        push_item(CMD_PARSE, 5'd0, 8'h41);       // dropped after body end
        push_item(CMD_LOAD, 5'd0, 8'h7a);        // restart
        push_item(CMD_PARSE, 5'd0, 8'h00);       // bad boundary byte
        push_item(CMD_PARSE, 5'd0, 8'h7a);       // dropped while in error
        wait_drained(SETTLE_CYCLES);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct  = send_pct[ph % 4];
            recv_stall_pct = recv_pct[ph % 4];
            write_len(len_plan[ph]);
            // fresh boundary for this setting
            for (int i = 0; i < bnd_len; i++) begin
                bnd_mirror[i] = boundary_char();
                push_item(CMD_LOAD, 5'(i), bnd_mirror[i]);
            end
            start_cnt = n_body;
            gen_body();
            if (ph == 3)
                holdoff_left = 150;   // block fills up while the sender keeps going
            // sender pause mid-phase until the block is empty
            wait_drained(0);
            while (n_body - start_cnt < PHASE_BYTES) begin
                gen_body();
                wait_drained(0);
            end
            wait_drained(SETTLE_CYCLES);
        end

        $display("covered %0d body bytes and %0d table loads over %0d length settings",
                 n_body, n_loads, n_settings);
        $display("checked %0d result beats, kinds seen %b", n_checked, kinds_seen[9:0]);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/mbp_pkg.sv
hw/rtl/multipart_body_parser_core.sv
verif/testbench.sv
